// ===== hdl/feedback_priority_task_dispatcher_unit_assert.svh =====
// Assertion macros for the feedback priority task dispatcher.
`ifndef FEEDBACK_PRIORITY_TASK_DISPATCHER_UNIT_ASSERT_SVH
`define FEEDBACK_PRIORITY_TASK_DISPATCHER_UNIT_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define FPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define FPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher assertion failed");

`endif

// ===== hdl/fpd_pkg.sv =====
// Shared types and constants of the feedback priority task dispatcher.
package fpd_pkg;

    localparam int MAX_TASKS_DEF = 32;

    localparam logic [7:0] TIMEOUT_RST = 8'd20;
    localparam logic [1:0] LEVEL_RST   = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_LEVEL   = 1'b1;

    localparam logic [2:0] EV_TIMEOUT  = 3'd0;
    localparam logic [2:0] EV_SUSPEND  = 3'd1;
    localparam logic [2:0] EV_START    = 3'd2;
    localparam logic [2:0] EV_CONTINUE = 3'd3;
    localparam logic [2:0] EV_FINISH   = 3'd4;

    // One task table entry.
    typedef struct packed {
        logic [13:0] id;
        logic [15:0] arrival;
        logic [1:0]  prio;
        logic [7:0]  remaining;
        logic        admitted;
    } entry_t;

    // One reported event.
    typedef struct packed {
        logic [2:0]  res;
        logic [13:0] task_id;
        logic [15:0] when;
        logic [1:0]  prio;
        logic [7:0]  remaining;
    } event_t;

    // Cell controls.
    typedef struct packed {
        logic shift;
        logic load;
        logic update;
    } cell_ctl_t;

endpackage

// ===== hdl/fpd_if.sv =====
// Stream interfaces for task input beats and event output beats.
interface fpd_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [13:0] task_id;
    logic [15:0] arrive_tick;
    logic [1:0]  start_priority;
    logic [7:0]  burst_time;

    modport source (output valid, command, task_id, arrive_tick, start_priority,
                    burst_time, input ready);
    modport sink (input valid, command, task_id, arrive_tick, start_priority,
                  burst_time, output ready);
endinterface

interface fpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [13:0] event_task;
    logic [15:0] event_time;
    logic [1:0]  event_priority;
    logic [7:0]  event_remaining;
    logic        last;

    modport source (output valid, event_res, event_task, event_time, event_priority,
                    event_remaining, last, input ready);
    modport sink (input valid, event_res, event_task, event_time, event_priority,
                  event_remaining, last, output ready);
endinterface

// ===== hdl/fpd_cell.sv =====
// One task table cell of the rotating chain.
module fpd_cell
(
    input  logic              clk,
    input  fpd_pkg::cell_ctl_t ctl,
    input  fpd_pkg::entry_t   shift_in,
    input  fpd_pkg::entry_t   load_data,
    input  logic [1:0]        upd_prio,
    input  logic [7:0]        upd_rem,
    output fpd_pkg::entry_t   q
);

    fpd_pkg::entry_t entry_reg;
    fpd_pkg::entry_t entry_next;

    // Take the neighbour's entry, a new load, or a service update
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            entry_next = shift_in;
        end
        else if (ctl.load)
        begin
            entry_next = load_data;
        end
        else if (ctl.update)
        begin
            entry_next.prio      = upd_prio;
            entry_next.remaining = upd_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// ===== hdl/feedback_priority_task_dispatcher_unit.sv =====
// Top level of the feedback priority task dispatcher.
// Usage:
//   in_ch carries load and tick beats; out_ch carries event beats, the final
//   event of a tick marked by last. The APB port writes timeout_limit at
//   address 0 and lowest_level at address 4; pready is always high.
//   A load beat writes the next free cell. A full table drops the load.
//   A tick rotates the chain of MAX_TASKS cells once round, one cell a cycle
//   unless a timeout event is held up, admitting, killing and picking on the
//   entry at the head; timeout events leave during the rotation. Suspend,
//   service and finish events follow in that order, then the flush state
//   pushes the last event. The block takes one beat at a time.
//   Each event is held one stage so last can be set; the output register
//   parts the block from the receiver. A stalled receiver freezes the
//   rotation only when a new event must be pushed.
//   Reset empties the table, clears time and the running task, and loads the
//   register defaults (timeout 20, lowest level 3).
module feedback_priority_task_dispatcher_unit
#(
    parameter int MAX_TASKS = fpd_pkg::MAX_TASKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    fpd_in_if.sink      in_ch,
    fpd_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PASS  = 3'd1;
    localparam logic [2:0] ST_SUSP  = 3'd2;
    localparam logic [2:0] ST_SERVE = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    total_reg, total_next;
    logic [15:0]      now_reg, now_next;
    logic [IW-1:0]    ri_reg, ri_next;
    logic             rv_reg, rv_next;
    logic [IW-1:0]    pos_reg, pos_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    pick_reg, pick_next;
    logic [13:0]      best_id_reg, best_id_next;
    logic [1:0]       best_prio_reg, best_prio_next;
    logic [7:0]       best_rem_reg, best_rem_next;
    logic [13:0]      run_id_reg, run_id_next;
    logic [1:0]       run_prio_reg, run_prio_next;
    logic [7:0]       run_rem_reg, run_rem_next;
    logic [7:0]       tlim_reg;
    logic [1:0]       level_reg;
    fpd_pkg::event_t  hold_reg, hold_next;
    logic             hold_valid_reg, hold_valid_next;
    fpd_pkg::event_t  out_reg, out_next;
    logic             out_last_reg, out_last_next;
    logic             out_valid_reg, out_valid_next;

    fpd_pkg::entry_t  cell_q [MAX_TASKS];
    fpd_pkg::entry_t  head;
    fpd_pkg::entry_t  head_mod;
    fpd_pkg::entry_t  load_data;
    logic             shift_en, load_en, upd_en;
    logic [1:0]       upd_prio;
    logic [7:0]       upd_rem;

    logic             active, adm_n, kill, elig, better, step_ok;
    logic [15:0]      age;
    logic             out_free, emit_ok, emit, push_out, push_last;
    fpd_pkg::event_t  ev_new;
    logic             accept;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == fpd_pkg::REG_LEVEL) ? {30'd0, level_reg} : {24'd0, tlim_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlim_reg  <= fpd_pkg::TIMEOUT_RST;
            level_reg <= fpd_pkg::LEVEL_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == fpd_pkg::REG_TIMEOUT)
            begin
                tlim_reg <= pwdata[7:0];
            end
            else
            begin
                level_reg <= pwdata[1:0];
            end
        end
    end

    // Cell chain: rotate towards the head, the edited head entry re-enters at the tail
    assign load_data = '{id: in_ch.task_id, arrival: in_ch.arrive_tick,
                         prio: in_ch.start_priority, remaining: in_ch.burst_time,
                         admitted: 1'b0};

    genvar k;
    generate
        for (k = 0; k < MAX_TASKS; k++)
        begin : g_cell
            fpd_pkg::cell_ctl_t ctl;
            fpd_pkg::entry_t    sin;

            assign ctl.shift  = shift_en;
            assign ctl.load   = load_en && (total_reg == CW'(k));
            assign ctl.update = upd_en && (pick_reg == IW'(k));
            if (k == MAX_TASKS - 1)
            begin : g_tail
                assign sin = head_mod;
            end
            else
            begin : g_mid
                assign sin = cell_q[k+1];
            end

            fpd_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .shift_in  (sin),
                .load_data (load_data),
                .upd_prio  (upd_prio),
                .upd_rem   (upd_rem),
                .q         (cell_q[k])
            );
        end
    endgenerate

    // Head cell evaluation: admit, kill on timeout, compare for the pick
    assign head   = cell_q[0];
    assign active = CW'(pos_reg) < total_reg;
    assign adm_n  = head.admitted || (head.arrival == now_reg);
    assign age    = now_reg - head.arrival;
    assign kill   = active && (head.remaining != 8'd0) && adm_n && (age >= {8'd0, tlim_reg});

    always_comb
    begin
        head_mod = head;
        if (active)
        begin
            head_mod.admitted = adm_n;
        end
        if (kill)
        begin
            head_mod.remaining = 8'd0;
        end
    end

    assign elig   = active && (head_mod.remaining != 8'd0) && (head.arrival <= now_reg);
    assign better = elig && (!found_reg || (head.prio < best_prio_reg));

    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit_ok  = !hold_valid_reg || out_free;
    assign step_ok  = !kill || emit_ok;
    assign accept   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    // Service update values for the picked task
    assign upd_rem  = best_rem_reg - 8'd1;
    assign upd_prio = ((best_prio_reg != 2'd0) && (upd_rem != 8'd0) && (best_prio_reg < level_reg))
                      ? best_prio_reg + 2'd1 : best_prio_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        now_next       = now_reg;
        ri_next        = ri_reg;
        rv_next        = rv_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_id_next   = best_id_reg;
        best_prio_next = best_prio_reg;
        best_rem_next  = best_rem_reg;
        run_id_next    = run_id_reg;
        run_prio_next  = run_prio_reg;
        run_rem_next   = run_rem_reg;
        shift_en       = 1'b0;
        load_en        = 1'b0;
        upd_en         = 1'b0;
        emit           = 1'b0;
        push_last      = 1'b0;
        ev_new         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.command == fpd_pkg::CMD_LOAD)
                    begin
                        if (total_reg < CW'(MAX_TASKS))
                        begin
                            load_en    = 1'b1;
                            total_next = total_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        pos_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                if (step_ok)
                begin
                    shift_en = 1'b1;
                    if (kill)
                    begin
                        emit   = 1'b1;
                        ev_new = '{res: fpd_pkg::EV_TIMEOUT, task_id: head.id, when: now_reg,
                                   prio: head.prio, remaining: head.remaining};
                        if (rv_reg && (ri_reg == pos_reg))
                        begin
                            rv_next = 1'b0;
                        end
                    end
                    if (better)
                    begin
                        found_next     = 1'b1;
                        pick_next      = pos_reg;
                        best_id_next   = head.id;
                        best_prio_next = head.prio;
                        best_rem_next  = head_mod.remaining;
                    end
                    if (ri_reg == pos_reg)
                    begin
                        run_id_next   = head.id;
                        run_prio_next = head.prio;
                        run_rem_next  = head_mod.remaining;
                    end
                    pos_next = pos_reg + IW'(1);
                    if (pos_reg == IW'(MAX_TASKS - 1))
                    begin
                        state_next = ST_SUSP;
                    end
                end
            end
            ST_SUSP:
            begin
                if (!found_reg)
                begin
                    now_next   = now_reg + 16'd1;
                    state_next = ST_FLUSH;
                end
                else if (rv_reg && (ri_reg != pick_reg) && (run_rem_reg != 8'd0))
                begin
                    if (emit_ok)
                    begin
                        emit       = 1'b1;
                        ev_new     = '{res: fpd_pkg::EV_SUSPEND, task_id: run_id_reg,
                                       when: now_reg, prio: run_prio_reg,
                                       remaining: run_rem_reg};
                        state_next = ST_SERVE;
                    end
                end
                else
                begin
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE:
            begin
                if (emit_ok)
                begin
                    emit   = 1'b1;
                    ev_new = '{res: (rv_reg && (ri_reg == pick_reg)) ? fpd_pkg::EV_CONTINUE
                                                                     : fpd_pkg::EV_START,
                               task_id: best_id_reg, when: now_reg, prio: best_prio_reg,
                               remaining: best_rem_reg};
                    now_next       = now_reg + 16'd1;
                    upd_en         = 1'b1;
                    best_prio_next = upd_prio;
                    if (upd_rem == 8'd0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ri_next    = pick_reg;
                        rv_next    = 1'b1;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FIN:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    ev_new     = '{res: fpd_pkg::EV_FINISH, task_id: best_id_reg,
                                   when: now_reg, prio: best_prio_reg, remaining: 8'd0};
                    rv_next    = 1'b0;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Event hold stage and output register
    assign push_out = (emit && hold_valid_reg) || push_last;

    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        if (push_out)
        begin
            out_next       = hold_reg;
            out_last_next  = push_last;
            out_valid_next = 1'b1;
        end
        if (emit)
        begin
            hold_next       = ev_new;
            hold_valid_next = 1'b1;
        end
        else if (push_last)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            total_reg      <= '0;
            now_reg        <= '0;
            ri_reg         <= '0;
            rv_reg         <= 1'b0;
            pos_reg        <= '0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            now_reg        <= now_next;
            ri_reg         <= ri_next;
            rv_reg         <= rv_next;
            pos_reg        <= pos_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg      <= pick_next;
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
        best_rem_reg  <= best_rem_next;
        run_id_reg    <= run_id_next;
        run_prio_reg  <= run_prio_next;
        run_rem_reg   <= run_rem_next;
        hold_reg      <= hold_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.event_res       = out_reg.res;
    assign out_ch.event_task      = out_reg.task_id;
    assign out_ch.event_time      = out_reg.when;
    assign out_ch.event_priority  = out_reg.prio;
    assign out_ch.event_remaining = out_reg.remaining;
    assign out_ch.last            = out_last_reg;

    // Checks
`include "feedback_priority_task_dispatcher_unit_assert.svh"

    `FPD_ASSERT_IMP(a_idle_no_hold, state_reg == ST_IDLE, !hold_valid_reg)
    `FPD_ASSERT_IMP(a_run_in_table, rv_reg, CW'(ri_reg) < total_reg)
    `FPD_ASSERT_IMP(a_total_bound, 1'b1, total_reg <= CW'(MAX_TASKS))
    `FPD_ASSERT_NEXT(a_flush_last, push_last, out_valid_reg && out_last_reg)

endmodule

// ===== bench/tb_feedback_priority_task_dispatcher_unit.sv =====
// Testbench for the feedback priority task dispatcher: predicted events checked beat by beat.
`timescale 1ns / 100ps

module tb_feedback_priority_task_dispatcher_unit;

    localparam int TABLE_SIZE = fpd_pkg::MAX_TASKS_DEF;
    localparam int IDLE_LIMIT = 10000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;

    // Dispatcher model and the queue of events it expects
    class dispatch_scoreboard;
        fpd_pkg::entry_t slots[TABLE_SIZE];
        int unsigned     slot_count;
        logic [15:0]     now;
        int unsigned     run_idx;
        bit              run_vld;
        logic [7:0]      timeout_lim;
        logic [1:0]      lowest_lvl;
        fpd_pkg::event_t pend_ev[$];
        bit              pend_last[$];
        int unsigned     errors;
        int unsigned     events_seen;
        int unsigned     ticks;
        int unsigned     loads;

        function new();
            slot_count = 0;
            now = '0;
            run_idx = 0;
            run_vld = 0;
            timeout_lim = fpd_pkg::TIMEOUT_RST;
            lowest_lvl = fpd_pkg::LEVEL_RST;
            errors = 0;
            events_seen = 0;
            ticks = 0;
            loads = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == fpd_pkg::REG_TIMEOUT)
                timeout_lim = value[7:0];
            else
                lowest_lvl = value[1:0];
        endfunction

        function fpd_pkg::event_t make_ev(logic [2:0] kind, int unsigned idx,
                                          logic [15:0] when);
            fpd_pkg::event_t ev;
            ev.res = kind;
            ev.task_id = slots[idx].id;
            ev.when = when;
            ev.prio = slots[idx].prio;
            ev.remaining = slots[idx].remaining;
            return ev;
        endfunction

        // Advance the model by one accepted input beat
        function void note_input(logic cmd, logic [13:0] id, logic [15:0] arr,
                                 logic [1:0] prio, logic [7:0] burst);
            fpd_pkg::event_t tick_ev[$];
            bit              found;
            int unsigned     pick;
            logic [15:0]     age;
            found = 0;
            pick = 0;
            if (cmd == fpd_pkg::CMD_LOAD)
            begin
                if (slot_count < TABLE_SIZE)
                begin
                    slots[slot_count] = '{id: id, arrival: arr, prio: prio,
                                          remaining: burst, admitted: 1'b0};
                    slot_count++;
                    loads++;
                end
                return;
            end
            ticks++;
            // Admit arrivals
            for (int i = 0; i < slot_count; i++)
                if (slots[i].arrival == now)
                    slots[i].admitted = 1'b1;
            // Kill tasks that waited too long
            for (int i = 0; i < slot_count; i++)
            begin
                age = now - slots[i].arrival;
                if (slots[i].remaining > 0 && slots[i].admitted && age >= timeout_lim)
                begin
                    tick_ev.push_back(make_ev(fpd_pkg::EV_TIMEOUT, i, now));
                    slots[i].remaining = '0;
                    if (run_vld && run_idx == i)
                        run_vld = 0;
                end
            end
            // Pick the eligible task with the best level, first index on a tie
            for (int i = 0; i < slot_count; i++)
                if (slots[i].remaining > 0 && slots[i].arrival <= now)
                    if (!found || slots[i].prio < slots[pick].prio)
                    begin
                        pick = i;
                        found = 1;
                    end
            if (found)
            begin
                if (!run_vld || run_idx != pick)
                begin
                    if (run_vld && slots[run_idx].remaining > 0)
                        tick_ev.push_back(make_ev(fpd_pkg::EV_SUSPEND, run_idx, now));
                    tick_ev.push_back(make_ev(fpd_pkg::EV_START, pick, now));
                end
                else
                    tick_ev.push_back(make_ev(fpd_pkg::EV_CONTINUE, pick, now));
                now = now + 16'd1;
                slots[pick].remaining = slots[pick].remaining - 8'd1;
                if (slots[pick].prio > 0 && slots[pick].remaining > 0
                    && slots[pick].prio < lowest_lvl)
                    slots[pick].prio = slots[pick].prio + 2'd1;
                if (slots[pick].remaining == 0)
                begin
                    tick_ev.push_back(make_ev(fpd_pkg::EV_FINISH, pick, now));
                    run_vld = 0;
                end
                else
                begin
                    run_idx = pick;
                    run_vld = 1;
                end
            end
            else
                now = now + 16'd1;
            foreach (tick_ev[k])
            begin
                pend_ev.push_back(tick_ev[k]);
                pend_last.push_back(k == tick_ev.size() - 1);
            end
        endfunction

        // Compare one event beat with the oldest expectation
        function void check_event(fpd_pkg::event_t got, bit got_last);
            fpd_pkg::event_t want;
            bit              want_last;
            events_seen++;
            if (pend_ev.size() == 0)
            begin
                $error("unexpected event beat: res %0d task %0d", got.res, got.task_id);
                errors++;
                return;
            end
            want = pend_ev.pop_front();
            want_last = pend_last.pop_front();
            if (got.res !== want.res)
            begin
                $error("event_res: expected %0d, got %0d", want.res, got.res);
                errors++;
            end
            if (got.task_id !== want.task_id)
            begin
                $error("event_task: expected %0d, got %0d", want.task_id, got.task_id);
                errors++;
            end
            if (got.when !== want.when)
            begin
                $error("event_time: expected %0d, got %0d", want.when, got.when);
                errors++;
            end
            if (got.prio !== want.prio)
            begin
                $error("event_priority: expected %0d, got %0d", want.prio, got.prio);
                errors++;
            end
            if (got.remaining !== want.remaining)
            begin
                $error("event_remaining: expected %0d, got %0d", want.remaining, got.remaining);
                errors++;
            end
            if (got_last !== want_last)
            begin
                $error("last: expected %0d, got %0d", want_last, got_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fpd_in_if  in_bus ();
    fpd_out_if out_bus ();

    dispatch_scoreboard sb;
    bit          hold_req;
    int unsigned idle_cycles;
    int unsigned sent_ticks;
    int unsigned counted;

    feedback_priority_task_dispatcher_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_bus.sink),
        .out_ch  (out_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random gap length: mostly short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Register write: setup cycle, then access cycle
    task automatic reg_write(logic idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Offer one beat and hold it until taken
    task automatic send_beat(logic cmd, logic [13:0] id, logic [15:0] arr,
                             logic [1:0] prio, logic [7:0] burst);
        int unsigned gap;
        in_bus.valid <= 1'b1;
        in_bus.command <= cmd;
        in_bus.task_id <= id;
        in_bus.arrive_tick <= arr;
        in_bus.start_priority <= prio;
        in_bus.burst_time <= burst;
        do
            @(posedge clk);
        while (!in_bus.ready);
        if (cmd == fpd_pkg::CMD_TICK)
            sent_ticks++;
        gap = gap_len();
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic tick();
        send_beat(fpd_pkg::CMD_TICK, 14'($urandom_range(0, 9999)), 16'($urandom),
                  2'($urandom), 8'($urandom));
    endtask

    // Drain all events, then let a silent tick finish
    task automatic settle();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pend_ev.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random mix of loads and ticks
    task automatic random_phase(int unsigned n);
        int unsigned done_n;
        int unsigned r;
        logic [15:0] arr;
        logic [7:0]  burst;
        done_n = 0;
        while (done_n < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    arr = 16'(sent_ticks + $urandom_range(0, 6));
                else if (r < 90)
                    arr = 16'($urandom_range(0, sent_ticks));
                else
                    arr = 16'($urandom);
                r = $urandom_range(0, 99);
                if (r < 70)
                    burst = 8'($urandom_range(1, 6));
                else if (r < 85)
                    burst = '0;
                else
                    burst = 8'($urandom);
                // a load into a full table is dropped and not counted
                if (sb.slot_count < TABLE_SIZE)
                    done_n++;
                else if ($urandom_range(0, 3) != 0)
                    continue;
                send_beat(fpd_pkg::CMD_LOAD, 14'($urandom_range(0, 9999)), arr,
                          2'($urandom), burst);
            end
            else
            begin
                tick();
                done_n++;
            end
        end
        counted += n;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
            else
            begin
                out_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Observe accepted beats on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (in_bus.valid && in_bus.ready)
            begin
                sb.note_input(in_bus.command, in_bus.task_id, in_bus.arrive_tick,
                              in_bus.start_priority, in_bus.burst_time);
                idle_cycles <= 0;
            end
            if (out_bus.valid && out_bus.ready)
            begin
                sb.check_event({out_bus.event_res, out_bus.event_task, out_bus.event_time,
                                out_bus.event_priority, out_bus.event_remaining},
                               out_bus.last);
                idle_cycles <= 0;
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    initial
    begin
        @(posedge rst_n);
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        hold_req = 0;
        idle_cycles = 0;
        sent_ticks = 0;
        counted = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.command = fpd_pkg::CMD_LOAD;
        in_bus.task_id = '0;
        in_bus.arrive_tick = '0;
        in_bus.start_priority = '0;
        in_bus.burst_time = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: field extremes, every level, zero burst, late load
        reg_write(fpd_pkg::REG_TIMEOUT, 32'd20);
        reg_write(fpd_pkg::REG_LEVEL, 32'd3);
        send_beat(fpd_pkg::CMD_LOAD, 14'd0, 16'd0, 2'd1, 8'd3);
        send_beat(fpd_pkg::CMD_LOAD, 14'd9999, 16'd0, 2'd0, 8'd2);
        send_beat(fpd_pkg::CMD_LOAD, 14'd8191, 16'd1, 2'd3, 8'd255);
        send_beat(fpd_pkg::CMD_LOAD, 14'd77, 16'd1, 2'd2, 8'd0);
        tick();
        tick();
        tick();
        send_beat(fpd_pkg::CMD_LOAD, 14'd42, 16'd1, 2'd0, 8'd2);
        send_beat(fpd_pkg::CMD_LOAD, 14'd5, 16'd65535, 2'd2, 8'd1);
        tick();
        tick();
        tick();
        tick();
        counted += 13;
        settle();

        // Long receiver hold-off while beats keep coming
        hold_req = 1;
        random_phase(85);
        settle();

        reg_write(fpd_pkg::REG_TIMEOUT, 32'd1);
        reg_write(fpd_pkg::REG_LEVEL, 32'd1);
        random_phase(85);
        settle();

        reg_write(fpd_pkg::REG_TIMEOUT, 32'd255);
        reg_write(fpd_pkg::REG_LEVEL, 32'd2);
        random_phase(85);
        settle();

        reg_write(fpd_pkg::REG_TIMEOUT, 32'd7);
        reg_write(fpd_pkg::REG_LEVEL, 32'd3);
        random_phase(85);
        settle();

        $display("Ran %0d counted beats: %0d loads kept, %0d ticks, %0d events checked,",
                 counted, sb.loads, sb.ticks, sb.events_seen);
        $display("over four register settings including the extremes of both fields.");
        if (sb.errors == 0 && sb.pend_ev.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
